@@ sv/tdpf_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the trial-division prime filter.
// No dependencies; used by every module of the block.
package tdpf_pkg;

	localparam int VALUE_WIDTH_DEF = 24;
	localparam int LIMIT_W         = 13;
	localparam int TRIAL_W         = LIMIT_W + 1;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;
	localparam logic [LIMIT_W-1:0] DIV_3       = 13'd3;
	localparam logic [LIMIT_W-1:0] DIV_5       = 13'd5;
	localparam logic [LIMIT_W-1:0] DIV_7       = 13'd7;
	localparam logic [TRIAL_W-1:0] TRIAL_FIRST = 14'd3;
	localparam logic [TRIAL_W-1:0] TRIAL_STEP  = 14'd2;

	typedef enum logic [1:0] {
		SEL_3,
		SEL_5,
		SEL_7,
		SEL_TRIAL
	} div_sel_t;

	// controller -> datapath
	typedef struct packed {
		logic     load;
		logic     div_start;
		div_sel_t div_sel;
		logic     trial_init;
		logic     trial_next;
		logic     publish;
		logic     pass;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic cand_odd;
		logic div_done;
		logic rem_zero;
		logic trial_end;
		logic out_free;
	} dp_stat_t;

endpackage

@@ sv/trial_division_prime_filter_top.sv @@
`timescale 1ns / 1ps
// Trial-division prime filter, top level; built from tdpf_pkg, tdpf_ctrl and tdpf_dp.
// Sequence, request accepted to result valid: an even candidate is rejected without division; an odd
//   one runs the fixed tests by 3/5/7, then one division per odd trial divisor, then a final
//   limit check if no divisor hits; each division runs on the one-bit-per-cycle remainder unit.
// Throughput: one request in flight; the next is accepted once its result is registered.
// Reset (arst_n low, asynchronous): divisor_limit = 4096, survivor count = 0, no result.
module trial_division_prime_filter_top #(
	parameter int VALUE_WIDTH = tdpf_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// request in
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [((VALUE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,  // candidate, zero pad
	input  logic                                 s_axis_tlast,  // last_in_range
	// result out
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [((2*VALUE_WIDTH+7)/8)*8-1:0]   m_axis_tdata,  // tested_value, survivor_total, pad
	output logic                                 m_axis_tuser,  // survives
	output logic                                 m_axis_tlast,  // range_done
	// divisor_limit register
	input  logic                                 cfg_wen,
	input  logic [tdpf_pkg::LIMIT_W-1:0]         cfg_wdata
);

	localparam int OUT_W = ((2*VALUE_WIDTH+7)/8)*8;

	tdpf_pkg::ctrl_cmd_t    cmd;
	tdpf_pkg::dp_stat_t     stat;
	logic [VALUE_WIDTH-1:0] out_value;
	logic [VALUE_WIDTH-1:0] out_total;

	// Sequencer: accept, fixed tests by 3/5/7, then odd trial divisors.
	tdpf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Remainder unit, counters and the result register.
	tdpf_dp #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.in_candidate (s_axis_tdata[VALUE_WIDTH-1:0]),
		.in_last      (s_axis_tlast),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_value    (out_value),
		.out_survives (m_axis_tuser),
		.out_total    (out_total),
		.out_last     (m_axis_tlast)
	);

	assign m_axis_tdata = OUT_W'({out_total, out_value});

endmodule

@@ sv/tdpf_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencing state machine of the prime filter.
// Depends on tdpf_pkg; drives tdpf_dp through ctrl_cmd_t / dp_stat_t.
module tdpf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  tdpf_pkg::dp_stat_t   stat,
	output tdpf_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_TRIAL,
		ST_FINISH
	} state_t;

	state_t             state_q;
	tdpf_pkg::div_sel_t sel_q;
	logic               pass_q;

	function automatic tdpf_pkg::div_sel_t next_sel(input tdpf_pkg::div_sel_t s);
		case (s)
			tdpf_pkg::SEL_3: next_sel = tdpf_pkg::SEL_5;
			tdpf_pkg::SEL_5: next_sel = tdpf_pkg::SEL_7;
			default:         next_sel = tdpf_pkg::SEL_TRIAL;
		endcase
	endfunction

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd         = '0;
		cmd.div_sel = sel_q;
		cmd.pass    = pass_q;
		case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
			end
			ST_CHECK: begin
				if (stat.cand_odd) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = tdpf_pkg::SEL_3;
				end
			end
			ST_DIV: begin
				if (stat.div_done && !stat.rem_zero) begin
					case (sel_q)
						tdpf_pkg::SEL_3, tdpf_pkg::SEL_5: begin
							cmd.div_start = 1'b1;
							cmd.div_sel   = next_sel(sel_q);
						end
						tdpf_pkg::SEL_7:     cmd.trial_init = 1'b1;
						tdpf_pkg::SEL_TRIAL: cmd.trial_next = 1'b1;
						default: ;
					endcase
				end
			end
			ST_TRIAL: begin
				if (!stat.trial_end) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = tdpf_pkg::SEL_TRIAL;
				end
			end
			ST_FINISH: begin
				cmd.publish = stat.out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= tdpf_pkg::SEL_3;
			pass_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (stat.cand_odd) begin
						sel_q   <= tdpf_pkg::SEL_3;
						state_q <= ST_DIV;
					end else begin
						pass_q  <= 1'b0;
						state_q <= ST_FINISH;
					end
				end
				ST_DIV: begin
					if (stat.div_done) begin
						if (stat.rem_zero) begin
							pass_q  <= 1'b0;
							state_q <= ST_FINISH;
						end else if (sel_q == tdpf_pkg::SEL_3 || sel_q == tdpf_pkg::SEL_5) begin
							sel_q <= next_sel(sel_q);
						end else begin
							state_q <= ST_TRIAL;
						end
					end
				end
				ST_TRIAL: begin
					if (stat.trial_end) begin
						pass_q  <= 1'b1;
						state_q <= ST_FINISH;
					end else begin
						sel_q   <= tdpf_pkg::SEL_TRIAL;
						state_q <= ST_DIV;
					end
				end
				ST_FINISH: begin
					if (stat.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ sv/tdpf_dp.sv @@
`timescale 1ns / 1ps
// Datapath: candidate hold, bit-serial remainder unit, trial divisor
// counter, survivor count and output register. Depends on tdpf_pkg.
module tdpf_dp #(
	parameter int VALUE_WIDTH = tdpf_pkg::VALUE_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tdpf_pkg::ctrl_cmd_t          cmd,
	output tdpf_pkg::dp_stat_t           stat,
	input  logic [VALUE_WIDTH-1:0]       in_candidate,
	input  logic                         in_last,
	input  logic                         cfg_wen,
	input  logic [tdpf_pkg::LIMIT_W-1:0] cfg_wdata,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [VALUE_WIDTH-1:0]       out_value,
	output logic                         out_survives,
	output logic [VALUE_WIDTH-1:0]       out_total,
	output logic                         out_last
);

	localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
	localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(VALUE_WIDTH);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	logic [tdpf_pkg::LIMIT_W-1:0] limit_q;
	logic [VALUE_WIDTH-1:0]       cand_q;
	logic                         last_q;
	logic [tdpf_pkg::TRIAL_W-1:0] trial_q;

	// remainder unit
	logic [VALUE_WIDTH-1:0]       dividend_q;
	logic [tdpf_pkg::LIMIT_W-1:0] dvs_q;
	logic [tdpf_pkg::LIMIT_W-1:0] rem_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic [tdpf_pkg::LIMIT_W:0]   rem_shift;
	logic [tdpf_pkg::LIMIT_W:0]   rem_sub;
	logic [tdpf_pkg::LIMIT_W-1:0] dvs_sel;

	logic [VALUE_WIDTH-1:0]       surv_q;
	logic [VALUE_WIDTH-1:0]       surv_next;
	logic                         out_valid_q;
	logic [VALUE_WIDTH-1:0]       out_value_q;
	logic                         out_pass_q;
	logic [VALUE_WIDTH-1:0]       out_total_q;
	logic                         out_last_q;

	always_comb begin
		case (cmd.div_sel)
			tdpf_pkg::SEL_3: dvs_sel = tdpf_pkg::DIV_3;
			tdpf_pkg::SEL_5: dvs_sel = tdpf_pkg::DIV_5;
			tdpf_pkg::SEL_7: dvs_sel = tdpf_pkg::DIV_7;
			default:         dvs_sel = trial_q[tdpf_pkg::LIMIT_W-1:0];
		endcase
	end

	assign rem_shift = {rem_q, dividend_q[VALUE_WIDTH-1]};
	assign rem_sub   = rem_shift - {1'b0, dvs_q};
	assign surv_next = surv_q + VALUE_WIDTH'(1);

	assign stat.cand_odd  = cand_q[0];
	assign stat.div_done  = done_q;
	assign stat.rem_zero  = (rem_q == '0);
	assign stat.trial_end = (trial_q >= {1'b0, limit_q});
	assign stat.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= tdpf_pkg::LIMIT_RESET;
			busy_q      <= 1'b0;
			done_q      <= 1'b0;
			surv_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) limit_q <= cfg_wdata;

			done_q <= busy_q && (cnt_q == CNT_ONE);
			if (cmd.div_start)
				busy_q <= 1'b1;
			else if (busy_q && cnt_q == CNT_ONE)
				busy_q <= 1'b0;

			if (cmd.publish) begin
				out_valid_q <= 1'b1;
				if (cmd.pass) surv_q <= surv_next;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cand_q <= in_candidate;
			last_q <= in_last;
		end
		if (cmd.trial_init)
			trial_q <= tdpf_pkg::TRIAL_FIRST;
		else if (cmd.trial_next)
			trial_q <= trial_q + tdpf_pkg::TRIAL_STEP;

		if (cmd.div_start) begin
			dvs_q      <= dvs_sel;
			dividend_q <= cand_q;
			rem_q      <= '0;
			cnt_q      <= CNT_LOAD;
		end else if (busy_q) begin
			// restoring step: one quotient bit per cycle
			dividend_q <= dividend_q << 1;
			cnt_q      <= cnt_q - CNT_ONE;
			if (rem_sub[tdpf_pkg::LIMIT_W])
				rem_q <= rem_shift[tdpf_pkg::LIMIT_W-1:0];
			else
				rem_q <= rem_sub[tdpf_pkg::LIMIT_W-1:0];
		end

		if (cmd.publish) begin
			out_value_q <= cand_q;
			out_pass_q  <= cmd.pass;
			out_total_q <= cmd.pass ? surv_next : surv_q;
			out_last_q  <= last_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_value    = out_value_q;
	assign out_survives = out_pass_q;
	assign out_total    = out_total_q;
	assign out_last     = out_last_q;

endmodule

@@ sv/tdpf_chk.sv @@
`timescale 1ns / 1ps
// Port-level checker for the prime filter, bound to the top level.
// Depends on tdpf_pkg and the trial_division_prime_filter_top ports only.
module tdpf_chk #(
	parameter int VALUE_WIDTH = tdpf_pkg::VALUE_WIDTH_DEF
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_axis_tvalid,
	input logic                               s_axis_tready,
	input logic                               m_axis_tvalid,
	input logic                               m_axis_tready,
	input logic [((2*VALUE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	input logic                               m_axis_tuser
);

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// a survivor is never even
	a_odd: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[0])
		else $error("even value flagged as survivor");

	// one candidate at a time
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second request taken while busy");

	// a new result means the sequencer is back ready
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> s_axis_tready)
		else $error("result issued without returning to idle");

endmodule

bind trial_division_prime_filter_top tdpf_chk #(
	.VALUE_WIDTH (VALUE_WIDTH)
) u_tdpf_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

@@ dv/tdpf_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the trial-division prime filter: predicts each result from
// the accepted requests and the divisor limit, and compares. Depends on tdpf_pkg.
module tdpf_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	input  logic                         s_axis_tready,
	input  logic [23:0]                  s_axis_tdata,   // candidate
	input  logic                         s_axis_tlast,   // last_in_range
	input  logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	input  logic [47:0]                  m_axis_tdata,   // tested_value, survivor_total
	input  logic                         m_axis_tuser,   // survives
	input  logic                         m_axis_tlast,   // range_done
	input  logic                         cfg_wen,
	input  logic [tdpf_pkg::LIMIT_W-1:0] cfg_wdata,
	output int                           fail_count,
	output int                           pending
);

	typedef struct packed {
		logic [23:0] value;
		logic        survives;
		logic [23:0] total;
		logic        range_done;
	} verdict_t;

	verdict_t                    verdict_q[$];
	logic [tdpf_pkg::LIMIT_W-1:0] divisor_limit;
	logic [23:0]                 survivor_count;

	function automatic logic escapes_trial_division(input logic [23:0] n,
			input logic [tdpf_pkg::LIMIT_W-1:0] lim);
		int unsigned d;
		if (!n[0] || n % 3 == 0 || n % 5 == 0 || n % 7 == 0)
			return 1'b0;
		for (d = 3; d < lim; d++)
			if (n % d == 0)
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic compare_field(input string name, input logic [23:0] exp_v,
			input logic [23:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		verdict_t want;
		verdict_t got;
		if (!arst_n) begin
			divisor_limit  = tdpf_pkg::LIMIT_RESET;
			survivor_count = '0;
			verdict_q.delete();
			fail_count     = 0;
		end else begin
			if (cfg_wen)
				divisor_limit = cfg_wdata;
			// pop before push so a spurious result never pairs with a fresh request
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{m_axis_tdata[23:0], m_axis_tuser, m_axis_tdata[47:24], m_axis_tlast};
				if (verdict_q.size() == 0) begin
					$display("%0t: unexpected result, expected none actual value %0d",
						$time, got.value);
					fail_count++;
				end else begin
					want = verdict_q.pop_front();
					compare_field("tested_value", want.value, got.value);
					compare_field("survives", 24'(want.survives), 24'(got.survives));
					compare_field("survivor_total", want.total, got.total);
					compare_field("range_done", 24'(want.range_done),
						24'(got.range_done));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				want.value    = s_axis_tdata;
				want.survives = escapes_trial_division(s_axis_tdata, divisor_limit);
				if (want.survives)
					survivor_count = survivor_count + 24'd1;
				want.total      = survivor_count;
				want.range_done = s_axis_tlast;
				verdict_q = {verdict_q, want};
			end
		end
		pending = verdict_q.size();
	end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the prime filter testbench: clock, reset, request stimulus, result
// back-pressure and verdict. Depends on tdpf_pkg, the filter RTL and tdpf_checker.
module tb_top;

	// cycles with no request or result moving before the run is abandoned
	localparam int WATCHDOG_LIMIT = 600000;
	localparam int LIMIT_MIN      = 3;
	localparam int LIMIT_MAX      = 8191;
	localparam int RANDOM_PHASES  = 5;
	localparam int PHASE_REQUESTS = 20;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         s_axis_tvalid;
	logic                         s_axis_tready;
	logic [23:0]                  s_axis_tdata;   // candidate
	logic                         s_axis_tlast;   // last_in_range
	logic                         m_axis_tvalid;
	logic                         m_axis_tready = 1'b0;
	logic [47:0]                  m_axis_tdata;   // tested_value, survivor_total
	logic                         m_axis_tuser;   // survives
	logic                         m_axis_tlast;   // range_done
	logic                         cfg_wen;
	logic [tdpf_pkg::LIMIT_W-1:0] cfg_wdata;

	int fail_count;
	int pending;
	int idle_cycles = 0;
	int burst_left  = 0;
	int stall_mode  = 0;
	int stall_span  = 0;

	always #10 clk = ~clk;

	trial_division_prime_filter_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata)
	);

	tdpf_checker scoreboard (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	// Result back-pressure: for each random span pick a new mood - always
	// ready, coin toss, or mostly stalled (ready at random, one time in four).
	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_span <= $urandom_range(8, 80);
		end else begin
			stall_span <= stall_span - 1;
		end
		case (stall_mode)
			0:       m_axis_tready <= 1'b1;
			1:       m_axis_tready <= $urandom_range(0, 1);
			default: m_axis_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// Watchdog: restarts whenever a request or a result moves.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Offer one request and hold it until taken. Requests go out in bursts;
	// a random gap (possibly none) opens before each new burst.
	task automatic push_candidate(input logic [23:0] cand, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= cand;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
	endtask

	// Stop offering and wait for every predicted result to come back.
	// The first edge lets the scoreboard log the final request.
	task automatic wait_drained;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// The limit may only change while the filter is idle: drain, let the
	// output register settle, then one write cycle.
	task automatic apply_limit(input int lim);
		wait_drained();
		repeat (8) @(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= lim[tdpf_pkg::LIMIT_W-1:0];
		@(posedge clk);
		cfg_wen   <= 1'b0;
	endtask

	initial begin
		int          ph;
		int          k;
		int          lim;
		int          p;
		int          q;
		logic [23:0] cand;

		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tlast  <= 1'b0;
		cfg_wen       <= 1'b0;
		cfg_wdata     <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset limit (4096): zero, one, even, all ones, candidates equal to a
		// trial divisor, and the largest 24-bit prime (full scan)
		push_candidate(24'd0, 1'b0);
		push_candidate(24'd1, 1'b0);
		push_candidate(24'd2, 1'b0);
		push_candidate(24'hFFFFFF, 1'b0);
		push_candidate(24'd11, 1'b0);
		push_candidate(24'd13, 1'b0);
		push_candidate(24'd16777213, 1'b1);

		// Widest limit: 4093*4099 is caught late, the big prime still survives
		apply_limit(LIMIT_MAX);
		push_candidate(24'd16777207, 1'b0);
		push_candidate(24'd16777213, 1'b1);

		// Narrowest limit: only the fixed 3/5/7 tests apply, so 121 and 143 pass
		apply_limit(LIMIT_MIN);
		push_candidate(24'd1, 1'b0);
		push_candidate(24'd9, 1'b0);
		push_candidate(24'd121, 1'b0);
		push_candidate(24'd143, 1'b1);
		push_candidate(24'h800001, 1'b0);
		push_candidate(24'd49, 1'b0);
		push_candidate(24'd11, 1'b1);

		// Limit 12: 11 now a divisor of itself, 13 just above; count carries
		// on across range markers
		apply_limit(12);
		push_candidate(24'd11, 1'b0);
		push_candidate(24'd13, 1'b0);
		push_candidate(24'd121, 1'b0);
		push_candidate(24'd169, 1'b0);
		push_candidate(24'd3, 1'b0);
		push_candidate(24'd5, 1'b0);
		push_candidate(24'd7, 1'b1);

		// Random phases, mostly small limits to keep scans short
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0:       lim = $urandom_range(LIMIT_MIN, 5);
				3:       lim = $urandom_range(65, 400);
				default: lim = $urandom_range(6, 64);
			endcase
			apply_limit(lim);
			for (k = 0; k < PHASE_REQUESTS; k++) begin
				case ($urandom_range(0, 3))
					0: cand = 24'($urandom);
					1: cand = {13'd0, 10'($urandom_range(0, 1023)), 1'b1};
					2: begin
						// product of a factor near the limit and an odd multiplier
						p    = $urandom_range(3, lim + 8);
						q    = 2 * $urandom_range(0, 2000) + 1;
						cand = 24'(p * q);
					end
					default: cand = 24'($urandom) | 24'd1;
				endcase
				push_candidate(cand, $urandom_range(0, 7) == 0);
			end
		end

		wait_drained();
		// catch any stray result after the last expected one
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
